/* rtl/assert_macros.svh */
// Assertion helpers. Both take a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/zrsil_pkg.sv */
package zrsil_pkg;

    localparam int MAX_PAIRS_DEF = 64;

    localparam int RUN_W      = 32;
    localparam int VALUE_W    = 64;
    localparam int IDX_W      = 38;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming request and prime the table read
        logic exec;     // carry out clear, append or an unused code
        logic step;     // examine one stored pair of a lookup
        logic load;     // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finish;   // the pair under examination ends the lookup
        logic out_free; // the output register can take a result this cycle
    } t_sts;

endpackage

/* rtl/zrsil_ctrl.sv */
module zrsil_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [zrsil_pkg::ACTION_W-1:0]      s_axis_tuser,
    input  zrsil_pkg::t_sts                     i_sts,
    output zrsil_pkg::t_cmd                     o_cmd
);

    zrsil_pkg::t_state r_state;
    zrsil_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zrsil_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            zrsil_pkg::S_IDLE: begin
                // No request is taken while reset is held.
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    if (s_axis_tuser == zrsil_pkg::ACT_LOOKUP) begin
                        n_state = zrsil_pkg::S_WALK;
                    end else begin
                        n_state = zrsil_pkg::S_EXEC;
                    end
                end
            end
            zrsil_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = zrsil_pkg::S_DONE;
            end
            zrsil_pkg::S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.finish) begin
                    n_state = zrsil_pkg::S_DONE;
                end
            end
            zrsil_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = zrsil_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = zrsil_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/zrsil_dp.sv */
module zrsil_dp #(
    parameter int MAX_PAIRS = zrsil_pkg::MAX_PAIRS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [zrsil_pkg::ACTION_W-1:0]      i_action,
    input  logic [zrsil_pkg::RUN_W-1:0]         i_zero_run,
    input  logic [zrsil_pkg::VALUE_W-1:0]       i_entry_value,
    input  logic [zrsil_pkg::IDX_W-1:0]         i_lookup_index,
    input  zrsil_pkg::t_cmd                     i_cmd,
    output zrsil_pkg::t_sts                     o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [zrsil_pkg::VALUE_W-1:0]       o_read_value,
    output logic [zrsil_pkg::STATUS_W-1:0]      o_status
);

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);
    // Position width: the virtual length is at most MAX_PAIRS * 2^32.
    localparam int PW = (zrsil_pkg::RUN_W + 1 + AW > zrsil_pkg::IDX_W) ?
                        (zrsil_pkg::RUN_W + 1 + AW) : zrsil_pkg::IDX_W;

    logic [zrsil_pkg::RUN_W-1:0]   run_mem [MAX_PAIRS];
    logic [zrsil_pkg::VALUE_W-1:0] val_mem [MAX_PAIRS];

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_idx;
    logic [CW-1:0]                 n_idx;
    logic [PW-1:0]                 r_pos;
    logic [zrsil_pkg::ACTION_W-1:0] r_action;
    logic [zrsil_pkg::RUN_W-1:0]   r_run_in;
    logic [zrsil_pkg::VALUE_W-1:0] r_value_in;
    logic [zrsil_pkg::IDX_W-1:0]   r_lookup;
    logic [zrsil_pkg::RUN_W-1:0]   r_rd_run;
    logic [zrsil_pkg::VALUE_W-1:0] r_rd_val;
    logic [zrsil_pkg::VALUE_W-1:0] r_res_value;
    zrsil_pkg::t_status            r_res_status;
    logic                          r_out_valid;
    logic [zrsil_pkg::VALUE_W-1:0] r_out_value;
    logic [zrsil_pkg::STATUS_W-1:0] r_out_status;

    logic [PW-1:0] sum;
    logic [PW-1:0] idx_ext;
    logic          at_end;
    logic          in_run;
    logic          at_value;
    logic          full;

    assign sum      = r_pos + PW'(r_rd_run);
    assign idx_ext  = PW'(r_lookup);
    assign at_end   = (r_idx >= r_count);
    assign in_run   = (idx_ext < sum);
    assign at_value = (idx_ext == sum);
    assign full     = (r_count >= CW'(MAX_PAIRS));

    assign o_sts.finish   = at_end | in_run | at_value;
    assign o_sts.out_free = !r_out_valid | i_out_ready;

    // The read address runs one pair ahead so that a pair is examined every cycle.
    always_comb begin
        if (i_cmd.capture) begin
            n_idx = '0;
        end else if (i_cmd.step && !o_sts.finish) begin
            n_idx = r_idx + CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_run <= run_mem[n_idx[AW-1:0]];
        r_rd_val <= val_mem[n_idx[AW-1:0]];
        if (i_cmd.exec && (r_action == zrsil_pkg::ACT_APPEND) && !full) begin
            run_mem[r_count[AW-1:0]] <= r_run_in;
            val_mem[r_count[AW-1:0]] <= r_value_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_run_in   <= i_zero_run;
            r_value_in <= i_entry_value;
            r_lookup   <= i_lookup_index;
            r_pos      <= '0;
        end
        if (i_cmd.exec) begin
            r_res_value <= '0;
            if ((r_action == zrsil_pkg::ACT_APPEND) && full) begin
                r_res_status <= zrsil_pkg::ST_FULL;
            end else begin
                r_res_status <= zrsil_pkg::ST_OK;
            end
        end
        if (i_cmd.step) begin
            priority if (at_end) begin
                r_res_value  <= '0;
                r_res_status <= zrsil_pkg::ST_RANGE;
            end else if (in_run) begin
                r_res_value  <= '0;
                r_res_status <= zrsil_pkg::ST_OK;
            end else if (at_value) begin
                r_res_value  <= r_rd_val;
                r_res_status <= zrsil_pkg::ST_OK;
            end else begin
                r_pos <= sum + PW'(1);
            end
        end
        if (i_cmd.load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_action)
                    zrsil_pkg::ACT_CLEAR: begin
                        r_count <= '0;
                    end
                    zrsil_pkg::ACT_APPEND: begin
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    default: begin
                        r_count <= r_count;
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

/* rtl/zero_run_sparse_index_lookup.sv */
// Sequence: a clear, append or unused code passes from acceptance through the execute state;
// a lookup walks the stored pairs, one per step, until it ends at a pair or runs beyond
// the virtual length. Either then waits in the done state until the output register has room.
// A new request is taken only once the previous one has loaded its result into the output
// register; a stalled result channel holds the done state.
// Reset: synchronous, active low; empties the table and the output register.
`include "assert_macros.svh"

module zero_run_sparse_index_lookup #(
    parameter int MAX_PAIRS = zrsil_pkg::MAX_PAIRS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: zero_run[31:0], entry_value[95:32], lookup_index[133:96],
    // then two zero bits of padding.
    input  logic [zrsil_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [zrsil_pkg::ACTION_W-1:0]      s_axis_tuser,
    // Result channel.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: read_value[63:0].
    output logic [zrsil_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [zrsil_pkg::STATUS_W-1:0]      m_axis_tuser
);

    // The table holds pairs of a zero-run length and one data value. The virtual
    // array lays each pair out as its run of zeros followed by its value. The
    // controller sequences each request; the datapath owns the pair table, the
    // running position of a lookup and the output register. The output register
    // lets the next request be taken while the previous result still waits.

    localparam int RUN_LO = 0;
    localparam int VAL_LO = RUN_LO + zrsil_pkg::RUN_W;
    localparam int IDX_LO = VAL_LO + zrsil_pkg::VALUE_W;

    logic [zrsil_pkg::RUN_W-1:0]   zero_run;
    logic [zrsil_pkg::VALUE_W-1:0] entry_value;
    logic [zrsil_pkg::IDX_W-1:0]   lookup_index;

    assign zero_run     = s_axis_tdata[RUN_LO +: zrsil_pkg::RUN_W];
    assign entry_value  = s_axis_tdata[VAL_LO +: zrsil_pkg::VALUE_W];
    assign lookup_index = s_axis_tdata[IDX_LO +: zrsil_pkg::IDX_W];

    zrsil_pkg::t_cmd cmd;
    zrsil_pkg::t_sts sts;

    // Sequencer: idle, execute a clear, append or unused code, walk the pairs, hand off the result.
    zrsil_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // A lookup examines one pair per cycle: it compares the index against the
    // running position plus the pair's run, which is one wide add and compare.
    zrsil_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (s_axis_tuser),
        .i_zero_run     (zero_run),
        .i_entry_value  (entry_value),
        .i_lookup_index (lookup_index),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_read_value   (m_axis_tdata),
        .o_status       (m_axis_tuser)
    );

    // Every accepted request starts the sequencer.
    `ASSERT_IMP(a_accept_captures, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, cmd.capture)
    // A result is only moved into the output register when it has room.
    `ASSERT_IMP(a_load_has_room, i_clk, i_rst_n, cmd.load, sts.out_free)
    // Once the pair walk finds its answer it stops.
    `ASSERT_NXT(a_walk_stops, i_clk, i_rst_n, cmd.step && sts.finish, !cmd.step)
    // A result whose status is not OK never carries a value.
    `ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != zrsil_pkg::ST_OK), m_axis_tdata == '0)

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import zrsil_pkg::*;

    localparam int MAX_PAIRS   = MAX_PAIRS_DEF;
    localparam int ITEM_TARGET = 1250;
    // The limit covers lookups that walk the full table, with both idle gaps added,
    // and allows several times over.
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = MAX_PAIRS + 8;

    // The fourth action code has no meaning and must leave the table alone.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
    } t_lookup_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0: zero_run[31:0], entry_value[95:32], lookup_index[133:96], padding.
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // Fields from bit 0: action[1:0].
    logic [ACTION_W-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0: read_value[63:0].
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // Fields from bit 0: status[1:0].
    logic [STATUS_W-1:0]  m_axis_tuser;

    zero_run_sparse_index_lookup #(
        .MAX_PAIRS(MAX_PAIRS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the pair table, updated as each request is accepted.
    int                 shadow_pair_count = 0;
    logic [RUN_W-1:0]   shadow_runs   [MAX_PAIRS];
    logic [VALUE_W-1:0] shadow_values [MAX_PAIRS];

    t_lookup_result pending_results[$];

    int  cycle_count     = 0;
    int  mismatches      = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  lookups_served  = 0;
    int  lookups_range   = 0;
    int  appends_refused = 0;
    bit  no_idle         = 1'b0;

    // Applies one request to the shadow table and returns the response it must produce.
    function automatic t_lookup_result sparse_response(logic [ACTION_W-1:0] act,
                                                       logic [RUN_W-1:0] run,
                                                       logic [VALUE_W-1:0] value,
                                                       logic [IDX_W-1:0] idx);
        t_lookup_result rsp;
        logic [63:0]    pos;
        logic [63:0]    want_idx;
        bit             found;
        int             k;
        rsp.read_value = '0;
        rsp.status     = ST_OK;
        case (act)
            ACT_CLEAR: begin
                shadow_pair_count = 0;
            end
            ACT_APPEND: begin
                if (shadow_pair_count >= MAX_PAIRS) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_runs[shadow_pair_count]   = run;
                    shadow_values[shadow_pair_count] = value;
                    shadow_pair_count++;
                end
            end
            ACT_LOOKUP: begin
                // Walk the pairs: each covers its zero run, then one data slot.
                pos      = '0;
                found    = 1'b0;
                want_idx = {26'd0, idx};
                for (k = 0; k < shadow_pair_count && !found; k++) begin
                    if (want_idx < pos + {32'd0, shadow_runs[k]}) begin
                        found = 1'b1;
                    end else begin
                        pos = pos + {32'd0, shadow_runs[k]};
                        if (want_idx == pos) begin
                            rsp.read_value = shadow_values[k];
                            found = 1'b1;
                        end
                        pos = pos + 64'd1;
                    end
                end
                if (!found) begin
                    rsp.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Virtual position of the data slot of pair k.
    function automatic logic [63:0] data_position(int k);
        logic [63:0] pos;
        int          i;
        pos = '0;
        for (i = 0; i < k; i++) begin
            pos = pos + {32'd0, shadow_runs[i]} + 64'd1;
        end
        return pos + {32'd0, shadow_runs[k]};
    endfunction

    function automatic logic [63:0] virtual_length();
        if (shadow_pair_count == 0) begin
            return '0;
        end
        return data_position(shadow_pair_count - 1) + 64'd1;
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[IDX_W-33:0], lo};
    endfunction

    // Mostly short runs so lookups land on every kind of position; some full-width runs.
    function automatic logic [RUN_W-1:0] pick_run();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
            return $urandom_range(0, 3);
        end else if (mode < 8) begin
            return $urandom_range(0, 40);
        end
        return $urandom;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0) begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    // Chooses a lookup index aimed at a data slot, a zero run, the end of the
    // virtual array or past it, or now and then at random.
    function automatic logic [IDX_W-1:0] pick_index();
        logic [63:0] span;
        logic [63:0] pos;
        logic [31:0] run;
        logic [31:0] off;
        int          k;
        int          mode;
        span = virtual_length();
        mode = $urandom_range(0, 9);
        if (shadow_pair_count == 0 || mode == 0) begin
            return random_index();
        end
        k   = $urandom_range(0, shadow_pair_count - 1);
        pos = data_position(k);
        run = shadow_runs[k];
        case (mode)
            5, 6: begin
                if (run != 0) begin
                    off = $urandom_range(0, run - 1);
                    pos = pos - 64'd1 - {32'd0, off};
                end
            end
            7: pos = span - 64'd1;
            8: pos = span;
            9: pos = span + {32'd0, $urandom};
            default: begin
            end
        endcase
        return pos[IDX_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Presents one request after a random gap, none when no_idle is set, and holds it until the block takes it.
    // The valid line is left high so that a following request can go back to back.
    task automatic send_request(logic [ACTION_W-1:0] act, logic [RUN_W-1:0] run,
                                logic [VALUE_W-1:0] value, logic [IDX_W-1:0] idx);
        t_lookup_result expected;
        int             gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, value, run};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        expected = sparse_response(act, run, value, idx);
        pending_results.push_back(expected);
        requests_sent++;
        if (act == ACT_LOOKUP) begin
            if (expected.status == ST_RANGE) begin
                lookups_range++;
            end else begin
                lookups_served++;
            end
        end
        if (expected.status == ST_FULL) begin
            appends_refused++;
        end
    endtask

    // Stops sending and waits until every outstanding request has been answered.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed_cases();
        no_idle = 1'b0;
        send_request(ACT_LOOKUP, '0, '0, '0);                        // empty table
        send_request(ACT_UNUSED, '1, '1, '1);                        // ignored code
        send_request(ACT_APPEND, 32'd0, '1, '0);                     // data slot at 0
        send_request(ACT_APPEND, 32'd3, 64'd0, '0);                  // zero value at 4
        send_request(ACT_APPEND, 32'd2, 64'h8000_0000_0000_0001, '0); // data slot at 7
        send_request(ACT_LOOKUP, '0, '0, 38'd0);
        send_request(ACT_LOOKUP, '0, '0, 38'd1);
        send_request(ACT_LOOKUP, '0, '0, 38'd3);
        send_request(ACT_LOOKUP, '0, '0, 38'd4);
        send_request(ACT_LOOKUP, '0, '0, 38'd6);
        send_request(ACT_LOOKUP, '0, '0, 38'd7);
        send_request(ACT_LOOKUP, '0, '0, 38'd8);                     // exactly the length
        send_request(ACT_LOOKUP, '1, '1, '1);                        // largest index
        send_request(ACT_CLEAR, '1, '1, '1);
        send_request(ACT_LOOKUP, '0, '0, 38'd0);                     // cleared table
        send_request(ACT_APPEND, '1, 64'h5A5A_A5A5_0F0F_F0F0, '1);   // longest zero run
        send_request(ACT_LOOKUP, '0, '0, 38'd0);
        send_request(ACT_LOOKUP, '0, '0, 38'hFFFF_FFFE);
        send_request(ACT_LOOKUP, '0, '0, 38'hFFFF_FFFF);
        send_request(ACT_LOOKUP, '0, '0, 38'h1_0000_0000);
        send_request(ACT_CLEAR, '0, '0, '0);
    endtask

    // Fills the table twice: once with the longest runs, so the last data slot sits
    // at the largest index, and once with empty runs. Appends beyond that are refused.
    task automatic test_full_table();
        int          i;
        logic [63:0] probe;
        no_idle = 1'b1;
        for (i = 0; i < MAX_PAIRS; i++) begin
            send_request(ACT_APPEND, '1, pick_value(), random_index());
        end
        send_request(ACT_LOOKUP, '0, '0, '1);
        send_request(ACT_LOOKUP, '0, '0, 38'd0);
        probe = data_position(MAX_PAIRS / 2) - 64'd1;
        send_request(ACT_LOOKUP, '0, '0, probe[IDX_W-1:0]);
        send_request(ACT_APPEND, 32'd5, '1, '0);
        send_request(ACT_APPEND, '0, 64'd1, '0);
        send_request(ACT_LOOKUP, '0, '0, '1);
        send_request(ACT_UNUSED, '0, '0, '0);
        no_idle = 1'b0;
        send_request(ACT_CLEAR, '0, '0, '0);
        for (i = 0; i < MAX_PAIRS; i++) begin
            send_request(ACT_APPEND, 32'd0, pick_value(), '0);
        end
        send_request(ACT_LOOKUP, '0, '0, 38'd0);
        send_request(ACT_LOOKUP, '0, '0, IDX_W'(MAX_PAIRS - 1));
        send_request(ACT_LOOKUP, '0, '0, IDX_W'(MAX_PAIRS));
        send_request(ACT_APPEND, '1, '1, '1);
        send_request(ACT_CLEAR, '0, '0, '0);
    endtask

    // Most traffic is a clear, a batch of appends, then a mix of lookups and further
    // appends. Short bursts of fully random requests are thrown in as noise, and the
    // sender now and then stops until the result queue has run dry.
    task automatic test_random_sequences();
        logic [31:0] raw;
        int          appends;
        int          tail;
        int          choice;
        int          i;
        int          drained_at;
        drained_at = requests_sent;
        while (requests_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                for (i = 0; i < 3; i++) begin
                    raw = $urandom;
                    send_request(raw[ACTION_W-1:0], $urandom, {$urandom, $urandom},
                                 random_index());
                end
            end else begin
                send_request(ACT_CLEAR, $urandom, {$urandom, $urandom}, random_index());
                appends = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_PAIRS - 4,
                                                                        MAX_PAIRS + 6)
                                                       : $urandom_range(1, 12);
                for (i = 0; i < appends; i++) begin
                    send_request(ACT_APPEND, pick_run(), pick_value(), random_index());
                end
                tail = $urandom_range(3, 15);
                for (i = 0; i < tail; i++) begin
                    choice = $urandom_range(0, 19);
                    if (choice < 15) begin
                        send_request(ACT_LOOKUP, $urandom, {$urandom, $urandom},
                                     pick_index());
                    end else if (choice < 18) begin
                        send_request(ACT_APPEND, pick_run(), pick_value(), random_index());
                    end else if (choice == 18) begin
                        send_request(ACT_UNUSED, $urandom, {$urandom, $urandom},
                                     random_index());
                    end else begin
                        send_request(ACT_LOOKUP, '0, '0, random_index());
                    end
                end
            end
            if (requests_sent - drained_at >= 200) begin
                wait_for_results();
                drained_at = requests_sent;
            end
        end
    endtask

    // Result side: drops ready for a random stall before each result, unless no_idle is set.
    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic check_result();
        t_lookup_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding: value %h status %0d",
                                      m_axis_tdata, m_axis_tuser));
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (m_axis_tdata !== want.read_value) begin
                report_mismatch($sformatf("read_value %h, expected %h",
                                          m_axis_tdata, want.read_value));
            end
            if (m_axis_tuser !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d",
                                          m_axis_tuser, want.status));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        wait_for_results();
        test_full_table();
        wait_for_results();
        test_random_sequences();
        wait_for_results();
        // Any stray result after the last one expected is caught by the checker.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d requests, %0d mismatches.",
                 results_checked, requests_sent, mismatches);
        $display("Lookups answered %0d, out of range %0d; appends refused on a full table %0d.",
                 lookups_served, lookups_range, appends_refused);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
